// ===== src/microwire_eeprom_controller_defines.svh =====
// Assertion helpers shared by the controller RTL.
`ifndef MICROWIRE_EEPROM_CONTROLLER_DEFINES_SVH
`define MICROWIRE_EEPROM_CONTROLLER_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define MEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MEC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/mec_pkg.sv =====
package mec_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned WordW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned StepW   = 5;
  localparam int unsigned BitCntW = 5;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [IndexW-1:0]  index_t;
  typedef logic [WordW-1:0]   word_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [StepW-1:0]   step_t;
  typedef logic [BitCntW-1:0] bit_cnt_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [7:0]         opcode_t;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_ERASE = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK              = 2'd0,
    ST_ERASE_TIMEOUT   = 2'd1,
    ST_WRITE_TIMEOUT   = 2'd2,
    ST_VERIFY_MISMATCH = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PHASE_TICKS  = 2'd0,
    REG_BUSY_TIMEOUT = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    K_SEL   = 4'd0,
    K_DESEL = 4'd1,
    K_SENDF = 4'd2,
    K_SENDI = 4'd3,
    K_ZERO4 = 4'd4,
    K_DATA  = 4'd5,
    K_RECV  = 4'd6,
    K_WLOW  = 4'd7,
    K_WHIGH = 4'd8
  } kind_e;

  localparam opcode_t OPC_READ  = 8'h80;
  localparam opcode_t OPC_EWEN  = 8'h30;
  localparam opcode_t OPC_ERASE = 8'hC0;
  localparam opcode_t OPC_WRITE = 8'h40;
  localparam opcode_t OPC_EWDS  = 8'h00;

  localparam logic [2:0] PIN_CS = 3'b100;
  localparam logic [2:0] PIN_SK = 3'b010;
  localparam logic [2:0] PIN_DI = 3'b001;

  localparam word_t PHASE_TICKS_RST  = 16'd1;
  localparam word_t BUSY_TIMEOUT_RST = 16'd10000;

  localparam step_t STEP_COUNT       = 5'd30;
  localparam step_t STEP_FIRST       = 5'd0;
  localparam step_t STEP_ERASE_END   = 5'd12;
  localparam step_t STEP_WRITE_BEGIN = 5'd13;
  localparam step_t STEP_WRITE_END   = 5'd25;
  localparam step_t STEP_READ_BEGIN  = 5'd26;
  localparam step_t STEP_READ_END    = 5'd29;

  // Clock counts (2 * clocks - 1) at which each shifting step ends.
  localparam bit_cnt_t LAST_SEND  = 5'd17;
  localparam bit_cnt_t LAST_ZERO4 = 5'd7;
  localparam bit_cnt_t LAST_WORD  = 5'd31;

  // One result beat.
  typedef struct packed {
    logic    chip_select;
    logic    serial_clock;
    logic    data_in_pin;
    logic    busy_res;
    logic    done_res;
    status_t status;
    word_t   read_data;
    logic    cmd_rejected;
  } result_t;

  function automatic kind_e step_kind(step_t s);
    kind_e k;
    unique case (s)
      5'd0, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd20, 5'd23, 5'd26: k = K_SEL;
      5'd1, 5'd11, 5'd14, 5'd24:                                   k = K_SENDF;
      5'd2:                                                        k = K_ZERO4;
      5'd5, 5'd17, 5'd27:                                          k = K_SENDI;
      5'd8, 5'd21:                                                 k = K_WLOW;
      5'd9, 5'd22:                                                 k = K_WHIGH;
      5'd18:                                                       k = K_DATA;
      5'd28:                                                       k = K_RECV;
      default:                                                     k = K_DESEL;
    endcase
    return k;
  endfunction

  function automatic opcode_t step_code(step_t s);
    opcode_t c;
    unique case (s)
      5'd1, 5'd14:  c = OPC_EWEN;
      5'd5:         c = OPC_ERASE;
      5'd17:        c = OPC_WRITE;
      5'd27:        c = OPC_READ;
      default:      c = OPC_EWDS;
    endcase
    return c;
  endfunction

endpackage

// ===== src/mec_in_if.sv =====
interface mec_in_if;
  import mec_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  index_t index;
  word_t  write_data;
  logic   do_level;

  modport source (output valid, command, index, write_data, do_level, input ready);
  modport sink   (input valid, command, index, write_data, do_level, output ready);
endinterface

// ===== src/mec_out_if.sv =====
interface mec_out_if;
  import mec_pkg::*;

  logic    valid;
  logic    ready;
  logic    chip_select;
  logic    serial_clock;
  logic    data_in_pin;
  logic    busy_res;
  logic    done_res;
  status_t status;
  word_t   read_data;
  logic    cmd_rejected;

  modport source (output valid, chip_select, serial_clock, data_in_pin, busy_res, done_res,
                  status, read_data, cmd_rejected, input ready);
  modport sink   (input valid, chip_select, serial_clock, data_in_pin, busy_res, done_res,
                  status, read_data, cmd_rejected, output ready);
endinterface

// ===== src/mec_cfg_if.sv =====
interface mec_cfg_if;
  import mec_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/microwire_eeprom_controller.sv =====
// Microwire master for a x16 serial EEPROM (93C46 style).
// in_i   : one beat per tick. command 0 is a plain tick; read, write (erase, write,
//          read-back verify) and erase start a sequence when the block is idle, and
//          that beat is already the first tick of the sequence. A command that
//          arrives while a sequence runs is dropped and flagged with cmd_rejected.
//          do_level carries the EEPROM DO pin sampled for this tick.
// out_o  : exactly one beat per input beat, in order: the CS/SK/DI levels for the
//          tick, busy, done with status and the word read on the last tick.
// cfg_i  : register writes (0 phase_ticks, 1 busy_timeout), always ready; write
//          only while idle. Zero in either register acts as one.
// Timing : each result beat is registered from its input beat. Throughput: one beat
//          per cycle while out_o.ready is high; the whole tick update (step table
//          lookup, one 16-bit phase compare, one 16-bit timeout compare) sits
//          between the state and the result register.
// Stall  : the result register holds while out_o.ready is low; in_i.ready follows
//          out_o.ready whenever a result is waiting, so no beat is lost.
// Reset  : rst_ni clears the sequencer to idle, drops the pending result and loads
//          phase_ticks = 1, busy_timeout = 10000.
`include "microwire_eeprom_controller_defines.svh"

module microwire_eeprom_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  mec_in_if.sink       in_i,
  mec_out_if.source    out_o,
  mec_cfg_if.sink      cfg_i
);
  import mec_pkg::*;

  // Configuration.
  word_t phase_ticks_q, busy_timeout_q;

  // Sequencer state.
  step_t    seq_step_q, seq_step_d;
  bit_cnt_t bit_count_q, bit_count_d;
  word_t    shift_word_q, shift_word_d;
  word_t    poll_count_q, poll_count_d;
  word_t    phase_count_q, phase_count_d;
  cmd_e     op_latch_q, op_latch_d;
  index_t   index_latch_q, index_latch_d;
  word_t    data_latch_q, data_latch_d;
  status_e  status_latch_q, status_latch_d;

  // Result register.
  result_t  res_q, res_d;
  logic     res_valid_q;

  logic     in_accept;
  cmd_e     cmd;

  // State as seen by this tick, after a possible command start.
  step_t    cur_step;
  bit_cnt_t cur_bits;
  word_t    cur_poll;
  word_t    cur_phase;
  cmd_e     cur_op;
  status_e  cur_status;
  word_t    cur_shift;

  step_t    s;
  kind_e    kind;
  opcode_t  code;
  logic [3:0] clk_num;
  logic     high;
  logic     bit_val;
  logic [2:0] pins;
  word_t    ticks, limit;
  logic     step_done, finish, rejected;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q  <= PHASE_TICKS_RST;
      busy_timeout_q <= BUSY_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PHASE_TICKS:  phase_ticks_q  <= cfg_i.data;
        REG_BUSY_TIMEOUT: busy_timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Take a new beat whenever the result register is empty or drains this cycle.
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;
  assign cmd        = cmd_e'(in_i.command);

  always_comb begin
    // Start a command when idle, flag it when busy.
    rejected      = 1'b0;
    cur_step      = seq_step_q;
    cur_bits      = bit_count_q;
    cur_poll      = poll_count_q;
    cur_phase     = phase_count_q;
    cur_op        = op_latch_q;
    cur_status    = status_latch_q;
    cur_shift     = shift_word_q;
    index_latch_d = index_latch_q;
    data_latch_d  = data_latch_q;
    if (op_latch_q == CMD_TICK) begin
      if (cmd != CMD_TICK) begin
        cur_op        = cmd;
        index_latch_d = in_i.index;
        data_latch_d  = in_i.write_data;
        cur_status    = ST_OK;
        cur_shift     = '0;
        cur_bits      = '0;
        cur_poll      = '0;
        cur_phase     = '0;
        cur_step      = (cmd == CMD_READ) ? STEP_READ_BEGIN : STEP_FIRST;
      end
    end else if (cmd != CMD_TICK) begin
      rejected = 1'b1;
    end

    seq_step_d     = cur_step;
    bit_count_d    = cur_bits;
    poll_count_d   = cur_poll;
    phase_count_d  = cur_phase;
    op_latch_d     = cur_op;
    status_latch_d = cur_status;
    shift_word_d   = cur_shift;

    s       = (cur_step < STEP_COUNT) ? cur_step : STEP_READ_END;
    kind    = step_kind(s);
    code    = step_code(s);
    clk_num = cur_bits[4:1];
    high    = cur_bits[0];
    ticks   = (phase_ticks_q != '0) ? phase_ticks_q : 16'd1;
    limit   = (busy_timeout_q != '0) ? busy_timeout_q : 16'd1;

    // Bit driven on DI: start bit on the first clock, then the opcode MSB first.
    if (kind == K_SENDI) begin
      code = code + {2'b00, index_latch_d};
    end
    bit_val = 1'b0;
    if (kind == K_SENDF || kind == K_SENDI) begin
      bit_val = (clk_num == 4'd0) ? 1'b1 : code[3'(3'd0 - clk_num[2:0])];
    end else if (kind == K_DATA) begin
      bit_val = data_latch_d[~clk_num];
    end

    case (kind)
      K_SEL:          pins = PIN_CS;
      K_DESEL:        pins = 3'b000;
      K_WLOW,
      K_WHIGH:        pins = (cur_bits == '0) ? PIN_CS : (PIN_CS | PIN_SK);
      default:        pins = PIN_CS | (high ? PIN_SK : 3'b000) | (bit_val ? PIN_DI : 3'b000);
    endcase

    // Hold each phase for the programmed ticks, then advance the step.
    step_done = 1'b0;
    if (cur_op == CMD_TICK) begin
      // Hold the sequencer while idle.
      phase_count_d = cur_phase;
    end else if (({1'b0, cur_phase} + 17'd1) < {1'b0, ticks}) begin
      phase_count_d = cur_phase + 16'd1;
    end else begin
      phase_count_d = '0;
      case (kind)
        K_SEL, K_DESEL: step_done = 1'b1;
        K_SENDF, K_SENDI: begin
          if (cur_bits >= LAST_SEND) step_done = 1'b1;
          else bit_count_d = cur_bits + 5'd1;
        end
        K_ZERO4: begin
          if (cur_bits >= LAST_ZERO4) step_done = 1'b1;
          else bit_count_d = cur_bits + 5'd1;
        end
        K_DATA: begin
          if (cur_bits >= LAST_WORD) step_done = 1'b1;
          else bit_count_d = cur_bits + 5'd1;
        end
        K_RECV: begin
          if (high) shift_word_d = {cur_shift[WordW-2:0], in_i.do_level};
          if (cur_bits >= LAST_WORD) step_done = 1'b1;
          else bit_count_d = cur_bits + 5'd1;
        end
        default: begin
          // Ready poll: clock low, clock high and sample, then one delay phase on a miss.
          if (cur_bits == 5'd0) begin
            bit_count_d = 5'd1;
          end else if (cur_bits == 5'd1) begin
            poll_count_d = cur_poll + 16'd1;
            if (in_i.do_level == (kind == K_WHIGH)) step_done = 1'b1;
            else bit_count_d = 5'd2;
          end else if (cur_poll >= limit) begin
            status_latch_d = (s < STEP_WRITE_BEGIN) ? ST_ERASE_TIMEOUT : ST_WRITE_TIMEOUT;
            step_done      = 1'b1;
          end else begin
            bit_count_d = 5'd0;
          end
        end
      endcase
    end

    finish = 1'b0;
    if (step_done) begin
      bit_count_d  = '0;
      poll_count_d = '0;
      if (s == STEP_ERASE_END) begin
        if (status_latch_d != ST_OK || cur_op == CMD_ERASE) finish = 1'b1;
        else seq_step_d = STEP_WRITE_BEGIN;
      end else if (s == STEP_WRITE_END) begin
        if (status_latch_d != ST_OK) finish = 1'b1;
        else seq_step_d = STEP_READ_BEGIN;
      end else if (s >= STEP_READ_END) begin
        if (cur_op == CMD_WRITE && shift_word_d != data_latch_d) begin
          status_latch_d = ST_VERIFY_MISMATCH;
        end
        finish = 1'b1;
      end else begin
        seq_step_d = s + 5'd1;
      end
    end

    res_d              = '0;
    res_d.cmd_rejected = rejected;
    if (finish) begin
      res_d.done_res  = 1'b1;
      res_d.status    = status_t'(status_latch_d);
      res_d.read_data = (cur_op != CMD_ERASE) ? shift_word_d : '0;
      op_latch_d      = CMD_TICK;
      seq_step_d      = STEP_FIRST;
    end

    // Idle ticks keep every pin low.
    if (cur_op == CMD_TICK) begin
      pins = 3'b000;
    end
    res_d.chip_select  = |(pins & PIN_CS);
    res_d.serial_clock = |(pins & PIN_SK);
    res_d.data_in_pin  = |(pins & PIN_DI);
    res_d.busy_res     = (op_latch_d != CMD_TICK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_step_q     <= STEP_FIRST;
      bit_count_q    <= '0;
      shift_word_q   <= '0;
      poll_count_q   <= '0;
      phase_count_q  <= '0;
      op_latch_q     <= CMD_TICK;
      index_latch_q  <= '0;
      data_latch_q   <= '0;
      status_latch_q <= ST_OK;
      res_valid_q    <= 1'b0;
    end else if (in_accept) begin
      seq_step_q     <= seq_step_d;
      bit_count_q    <= bit_count_d;
      shift_word_q   <= shift_word_d;
      poll_count_q   <= poll_count_d;
      phase_count_q  <= phase_count_d;
      op_latch_q     <= op_latch_d;
      index_latch_q  <= index_latch_d;
      data_latch_q   <= data_latch_d;
      status_latch_q <= status_latch_d;
      res_valid_q    <= 1'b1;
    end else if (out_o.ready) begin
      // Drop the result once it has been taken.
      res_valid_q <= 1'b0;
    end
  end

  // Payload register: advance only with an accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.chip_select  = res_q.chip_select;
  assign out_o.serial_clock = res_q.serial_clock;
  assign out_o.data_in_pin  = res_q.data_in_pin;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.status       = res_q.status;
  assign out_o.read_data    = res_q.read_data;
  assign out_o.cmd_rejected = res_q.cmd_rejected;

  `MEC_ASSERT_ALWAYS(a_ready_when_empty, !res_valid_q |-> in_i.ready,
                     "input stalled with an empty result register")
  `MEC_ASSERT(a_drain_clears, (res_valid_q && out_o.ready && !in_accept) |=> !res_valid_q,
              "result beat repeated after being taken")
  `MEC_ASSERT(a_idle_clean, (op_latch_q == CMD_TICK) |-> (seq_step_q == STEP_FIRST &&
              bit_count_q == '0 && poll_count_q == '0), "idle sequencer holds stale counters")
  `MEC_ASSERT(a_done_not_busy, (res_valid_q && res_q.done_res) |-> !res_q.busy_res,
              "completion reported while still busy")
  `MEC_ASSERT(a_status_with_done, (res_valid_q && !res_q.done_res) |-> res_q.status == '0,
              "status set without completion")

endmodule

// ===== tb/tb_microwire_eeprom_controller.sv =====
module tb_microwire_eeprom_controller;
  import mec_pkg::*;

  // Any stretch this long without a single accepted beat on any channel is a hang.
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned RANDOM_BEATS = 100;
  localparam int unsigned DRAIN_CYCLES = 8;
  // Register index that decodes to nothing; writes there must leave the block alone.
  localparam cfg_idx_t    REG_UNMAPPED = 2'd3;

  // How the emulated EEPROM answers the ready polls.
  typedef enum int {FAIL_NONE, FAIL_ERASE, FAIL_WRITE} poll_fail_e;

  logic clk_i;
  logic rst_ni;

  mec_in_if  in_if ();
  mec_out_if out_if ();
  mec_cfg_if cfg_if ();

  microwire_eeprom_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Sequencer mirror: step layout of one command, tracked tick by tick.
  // Erase part 0..12, write part 13..25, read part 26..29.
  // ---------------------------------------------------------------------------
  kind_e seq_kind [STEP_COUNT] = '{
    K_SEL, K_SENDF, K_ZERO4, K_DESEL, K_SEL, K_SENDI, K_DESEL, K_SEL, K_WLOW, K_WHIGH,
    K_SEL, K_SENDF, K_DESEL,
    K_SEL, K_SENDF, K_DESEL, K_SEL, K_SENDI, K_DATA, K_DESEL, K_SEL, K_WLOW, K_WHIGH,
    K_SEL, K_SENDF, K_DESEL,
    K_SEL, K_SENDI, K_RECV, K_DESEL
  };
  // Only the send steps look at their opcode; other entries are don't-care.
  opcode_t seq_code [STEP_COUNT] = '{
    OPC_EWDS, OPC_EWEN, OPC_EWDS, OPC_EWDS, OPC_EWDS, OPC_ERASE, OPC_EWDS, OPC_EWDS,
    OPC_EWDS, OPC_EWDS, OPC_EWDS, OPC_EWDS, OPC_EWDS,
    OPC_EWDS, OPC_EWEN, OPC_EWDS, OPC_EWDS, OPC_WRITE, OPC_EWDS, OPC_EWDS, OPC_EWDS,
    OPC_EWDS, OPC_EWDS, OPC_EWDS, OPC_EWDS, OPC_EWDS,
    OPC_EWDS, OPC_READ, OPC_EWDS, OPC_EWDS
  };

  // Mirrored registers and sequencer state.
  int unsigned m_phase_ticks  = PHASE_TICKS_RST;
  int unsigned m_busy_timeout = BUSY_TIMEOUT_RST;
  cmd_t        m_op           = CMD_TICK;
  int unsigned m_step         = 0;
  int unsigned m_bits         = 0;
  int unsigned m_polls        = 0;
  int unsigned m_phase        = 0;
  index_t      m_index        = '0;
  word_t       m_data         = '0;
  word_t       m_shift        = '0;
  status_t     m_status       = ST_OK;

  // Pin frames still owed by the block, oldest first.
  result_t due_frames[$];

  // EEPROM emulation knobs.
  word_t      reply_word   = '0;
  word_t      verify_flip  = '0;
  poll_fail_e wait_fail    = FAIL_NONE;
  int         poll_hit_pct = 100;
  int         do_noise_pct = 0;
  int         reject_pct   = 0;
  bit         src_stalls   = 1'b1;
  bit         sink_stalls  = 1'b1;

  // Bookkeeping.
  int unsigned mismatches   = 0;
  int unsigned beats_sent   = 0;
  int unsigned frames_seen  = 0;
  int unsigned done_by_op   [4];
  int unsigned status_count [4];
  int unsigned rejects      = 0;

  // ---------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Advance the mirrored sequencer by one tick and build the pin frame it owes.
  // ---------------------------------------------------------------------------
  task automatic sequencer_step(input cmd_t cmd, input index_t ix, input word_t wd,
                                input logic dl, output result_t r);
    kind_e       k;
    int unsigned s;
    int unsigned clk_no;
    int unsigned ticks;
    int unsigned limit;
    opcode_t     code;
    logic        hi;
    logic        sbit;
    logic        stepped;
    logic        fin;
    logic [2:0]  pins;
    r       = '0;
    pins    = '0;
    sbit    = 1'b0;
    stepped = 1'b0;
    fin     = 1'b0;

    // Latch a command only while idle; the same beat is the first tick.
    if (m_op == CMD_TICK) begin
      if (cmd != CMD_TICK) begin
        m_op     = cmd;
        m_index  = ix;
        m_data   = wd;
        m_status = ST_OK;
        m_shift  = '0;
        m_bits   = 0;
        m_polls  = 0;
        m_phase  = 0;
        m_step   = (cmd == CMD_READ) ? STEP_READ_BEGIN : STEP_FIRST;
      end
    end else if (cmd != CMD_TICK) begin
      r.cmd_rejected = 1'b1;
      rejects++;
    end

    if (m_op != CMD_TICK) begin
      s      = m_step;
      k      = seq_kind[s];
      clk_no = (m_bits >> 1) & 15;
      hi     = (m_bits & 1) != 0;
      ticks  = (m_phase_ticks != 0) ? m_phase_ticks : 1;
      limit  = (m_busy_timeout != 0) ? m_busy_timeout : 1;

      // Serial bit: start bit on the first clock, then the opcode MSB first.
      if (k == K_SENDF || k == K_SENDI) begin
        code = seq_code[s];
        if (k == K_SENDI) code = code + {2'b00, m_index};
        sbit = (clk_no == 0) ? 1'b1 : code[(8 - clk_no) & 7];
      end else if (k == K_DATA) begin
        sbit = m_data[15 - clk_no];
      end

      if (k == K_SEL)
        pins = PIN_CS;
      else if (k == K_DESEL)
        pins = '0;
      else if (k == K_WLOW || k == K_WHIGH)
        pins = (m_bits == 0) ? PIN_CS : (PIN_CS | PIN_SK);
      else
        pins = PIN_CS | (hi ? PIN_SK : 3'b000) | (sbit ? PIN_DI : 3'b000);

      // Hold each phase for phase_ticks ticks, then move the step along.
      if (m_phase + 1 < ticks) begin
        m_phase++;
      end else begin
        m_phase = 0;
        case (k)
          K_SEL, K_DESEL: stepped = 1'b1;
          K_SENDF, K_SENDI: begin
            if (m_bits >= LAST_SEND) stepped = 1'b1; else m_bits++;
          end
          K_ZERO4: begin
            if (m_bits >= LAST_ZERO4) stepped = 1'b1; else m_bits++;
          end
          K_DATA: begin
            if (m_bits >= LAST_WORD) stepped = 1'b1; else m_bits++;
          end
          K_RECV: begin
            if (hi) m_shift = {m_shift[14:0], dl};
            if (m_bits >= LAST_WORD) stepped = 1'b1; else m_bits++;
          end
          default: begin
            // Ready poll: low phase, sampling high phase, then a delay phase on a miss.
            if (m_bits == 0) begin
              m_bits = 1;
            end else if (m_bits == 1) begin
              m_polls++;
              if (dl == (k == K_WHIGH)) stepped = 1'b1;
              else m_bits = 2;
            end else if (m_polls >= limit) begin
              m_status = (s < STEP_WRITE_BEGIN) ? ST_ERASE_TIMEOUT : ST_WRITE_TIMEOUT;
              stepped  = 1'b1;
            end else begin
              m_bits = 0;
            end
          end
        endcase
      end

      if (stepped) begin
        m_bits  = 0;
        m_polls = 0;
        if (s == STEP_ERASE_END) begin
          if (m_status != ST_OK || m_op == CMD_ERASE) fin = 1'b1;
          else m_step = STEP_WRITE_BEGIN;
        end else if (s == STEP_WRITE_END) begin
          if (m_status != ST_OK) fin = 1'b1;
          else m_step = STEP_READ_BEGIN;
        end else if (s >= STEP_READ_END) begin
          if (m_op == CMD_WRITE && m_shift != m_data) m_status = ST_VERIFY_MISMATCH;
          fin = 1'b1;
        end else begin
          m_step = s + 1;
        end
        if (fin) begin
          r.done_res  = 1'b1;
          r.status    = m_status;
          r.read_data = (m_op != CMD_ERASE) ? m_shift : '0;
          done_by_op[m_op]++;
          status_count[m_status]++;
          m_op   = CMD_TICK;
          m_step = 0;
        end
      end
    end

    r.chip_select  = pins[2];
    r.serial_clock = pins[1];
    r.data_in_pin  = pins[0];
    r.busy_res     = (m_op != CMD_TICK);
  endtask

  // ---------------------------------------------------------------------------
  // Emulated EEPROM DO pin, chosen from where the sequencer stands right now.
  // ---------------------------------------------------------------------------
  function automatic logic pick_do_level();
    kind_e k;
    word_t w;
    logic  fail;
    logic  hit;
    if (m_op == CMD_TICK || $urandom_range(1, 100) <= do_noise_pct)
      return $urandom_range(0, 1) != 0;
    k = seq_kind[m_step];
    if (k == K_WLOW || k == K_WHIGH) begin
      fail = (wait_fail == FAIL_ERASE && m_step <  STEP_WRITE_BEGIN) ||
             (wait_fail == FAIL_WRITE && m_step >= STEP_WRITE_BEGIN);
      hit  = !fail && ($urandom_range(1, 100) <= poll_hit_pct);
      return (k == K_WHIGH) ? hit : !hit;
    end
    if (k == K_RECV) begin
      // Read back what was written (optionally corrupted), else the stored word.
      w = (m_op == CMD_WRITE) ? (m_data ^ verify_flip) : reply_word;
      return w[15 - (m_bits >> 1)];
    end
    return $urandom_range(0, 1) != 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: one tick beat, with an optional idle burst in front of it.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input cmd_t cmd, input index_t ix, input word_t wd);
    result_t frame;
    logic    dl;
    int      gap;
    if (src_stalls && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 19);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    dl = pick_do_level();
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.index      <= ix;
    in_if.write_data <= wd;
    in_if.do_level   <= dl;
    do @(posedge clk_i); while (!in_if.ready);
    sequencer_step(cmd, ix, wd, dl, frame);
    due_frames.push_back(frame);
    beats_sent++;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_beat(CMD_TICK, index_t'($urandom), word_t'($urandom));
  endtask

  // Issue a command and keep ticking until the sequencer is idle again.
  task automatic run_command(input cmd_t cmd, input index_t ix, input word_t wd);
    send_beat(cmd, ix, wd);
    while (m_op != CMD_TICK)
      send_beat(($urandom_range(1, 100) <= reject_pct) ? cmd_t'($urandom_range(1, 3)) : CMD_TICK,
                index_t'($urandom), word_t'($urandom));
  endtask

  // Finish any sequence, drop valid and wait for every owed frame.
  task automatic settle();
    while (m_op != CMD_TICK) send_beat(CMD_TICK, index_t'($urandom), word_t'($urandom));
    in_if.valid <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back, plus one write to an unmapped index.
  task automatic program_regs(input word_t ticks, input word_t timeout);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_PHASE_TICKS;
    cfg_if.data  <= ticks;
    do @(posedge clk_i); while (!cfg_if.ready);
    m_phase_ticks = ticks;
    cfg_if.index <= REG_BUSY_TIMEOUT;
    cfg_if.data  <= timeout;
    do @(posedge clk_i); while (!cfg_if.ready);
    m_busy_timeout = timeout;
    cfg_if.index <= REG_UNMAPPED;
    cfg_if.data  <= word_t'($urandom);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random back-pressure bursts.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (rst_ni && sink_stalls && $urandom_range(0, 11) == 0) begin
        n = $urandom_range(1, 19);
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame checker: every accepted result beat against the oldest owed frame.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : frame_check
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      frames_seen++;
      if (due_frames.size() == 0) begin
        $error("result beat arrived with no frame owed");
        mismatches++;
      end else begin
        want = due_frames.pop_front();
        check_field("chip_select",  16'(want.chip_select),  16'(out_if.chip_select));
        check_field("serial_clock", 16'(want.serial_clock), 16'(out_if.serial_clock));
        check_field("data_in_pin",  16'(want.data_in_pin),  16'(out_if.data_in_pin));
        check_field("busy_res",     16'(want.busy_res),     16'(out_if.busy_res));
        check_field("done_res",     16'(want.done_res),     16'(out_if.done_res));
        check_field("status",       16'(want.status),       16'(out_if.status));
        check_field("read_data",    want.read_data,         out_if.read_data);
        check_field("cmd_rejected", 16'(want.cmd_rejected), 16'(out_if.cmd_rejected));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any beat on any channel ends the run.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_microwire_eeprom_controller: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reads at reset settings, then with a zero phase count that must act as one.
  task automatic test_read_word();
    reply_word = 16'hFFFF;
    run_command(CMD_READ, 6'd63, 16'h0000);
    program_regs(16'd0, 16'd1);
    reply_word = 16'hA5C3;
    run_command(CMD_READ, 6'd42, word_t'($urandom));
  endtask

  // Erase at the top address with polls that take a few tries.
  task automatic test_erase_word();
    program_regs(16'd1, 16'd10000);
    poll_hit_pct = 50;
    run_command(CMD_ERASE, 6'd63, word_t'($urandom));
    poll_hit_pct = 100;
  endtask

  // Full write with verify: all-ones, then a corrupted read-back.
  task automatic test_write_word();
    run_command(CMD_WRITE, 6'd63, 16'hFFFF);
    verify_flip = 16'h0100;
    run_command(CMD_WRITE, 6'd21, 16'h1234);
    verify_flip = '0;
  endtask

  // Erase timeout inside a write, write timeout, erase timeout with a zero timeout.
  task automatic test_wait_timeouts();
    program_regs(16'd1, 16'd2);
    wait_fail = FAIL_ERASE;
    run_command(CMD_WRITE, 6'd10, word_t'($urandom));
    wait_fail = FAIL_WRITE;
    run_command(CMD_WRITE, 6'd11, word_t'($urandom));
    program_regs(16'd1, 16'd0);
    wait_fail = FAIL_ERASE;
    run_command(CMD_ERASE, 6'd12, word_t'($urandom));
    wait_fail = FAIL_NONE;
  endtask

  // Every beat during a running sequence carries a command; all must be dropped.
  task automatic test_busy_rejects();
    program_regs(16'd1, 16'd10000);
    reject_pct = 100;
    reply_word = word_t'($urandom);
    run_command(CMD_READ, 6'd33, word_t'($urandom));
    reject_pct = 0;
  endtask

  // Longer phases stretch every pin level over several ticks.
  task automatic test_phase_stretch();
    program_regs(16'd3, 16'd4);
    reply_word = word_t'($urandom);
    run_command(CMD_READ, 6'd17, word_t'($urandom));
  endtask

  // Register maxima: idle ticks under the longest phase, then an erase with the
  // longest timeout.
  task automatic test_register_extremes();
    program_regs(16'hFFFF, 16'hFFFF);
    idle_ticks(20);
    program_regs(16'd1, 16'hFFFF);
    run_command(CMD_ERASE, 6'd63, word_t'($urandom));
  endtask

  // Random well-formed command sequences with random EEPROM behavior, some
  // noise ticks and commands while busy.
  task automatic test_random_sequences();
    int unsigned start;
    int unsigned eff_timeout;
    start        = beats_sent;
    do_noise_pct = 4;
    while (beats_sent - start < RANDOM_BEATS) begin
      if ($urandom_range(0, 4) == 0)
        program_regs(word_t'($urandom_range(0, 2)),
                     ($urandom_range(0, 3) == 0) ? word_t'($urandom_range(7, 65535))
                                                 : word_t'($urandom_range(0, 6)));
      reply_word   = word_t'($urandom);
      verify_flip  = ($urandom_range(0, 7) == 0) ? word_t'($urandom_range(1, 65535)) : '0;
      poll_hit_pct = $urandom_range(20, 100);
      reject_pct   = $urandom_range(0, 8);
      case ($urandom_range(0, 7))
        0:       wait_fail = FAIL_ERASE;
        1:       wait_fail = FAIL_WRITE;
        default: wait_fail = FAIL_NONE;
      endcase
      // Only force a timeout when the timeout is short enough to expire quickly.
      eff_timeout = (m_busy_timeout != 0) ? m_busy_timeout : 1;
      if (eff_timeout > 8) wait_fail = FAIL_NONE;
      src_stalls  = $urandom_range(0, 2) != 0;
      sink_stalls = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 5) == 0) idle_ticks($urandom_range(1, 6));
      run_command(cmd_t'($urandom_range(1, 3)), index_t'($urandom), word_t'($urandom));
    end
    wait_fail    = FAIL_NONE;
    verify_flip  = '0;
    reject_pct   = 0;
    do_noise_pct = 0;
  endtask

  // Closing stretch at full rate: no idling on either side.
  task automatic test_steady_stream();
    src_stalls  = 1'b0;
    sink_stalls = 1'b0;
    program_regs(16'd1, 16'd3);
    poll_hit_pct = 70;
    repeat (2) begin
      reply_word = word_t'($urandom);
      run_command(cmd_t'($urandom_range(1, 3)), index_t'($urandom), word_t'($urandom));
    end
    idle_ticks(4);
  endtask

  // ---------------------------------------------------------------------------
  // Main flow.
  // ---------------------------------------------------------------------------
  initial begin : main_flow
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_TICK;
    in_if.index      <= '0;
    in_if.write_data <= '0;
    in_if.do_level   <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_PHASE_TICKS;
    cfg_if.data      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_read_word();
    test_erase_word();
    test_write_word();
    test_wait_timeouts();
    test_busy_rejects();
    test_phase_stretch();
    test_register_extremes();
    test_random_sequences();
    test_steady_stream();

    // Drain, then idle for DRAIN_CYCLES so that any stray beat would show.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_frames.size() != 0) begin
      $error("%0d frames never arrived", due_frames.size());
      mismatches += due_frames.size();
    end

    $display("%0d tick beats, %0d frames checked; finished %0d reads, %0d writes, %0d erases",
             beats_sent, frames_seen, done_by_op[CMD_READ], done_by_op[CMD_WRITE],
             done_by_op[CMD_ERASE]);
    $display("status ok %0d, erase timeout %0d, write timeout %0d, verify mismatch %0d; %0d %s",
             status_count[ST_OK], status_count[ST_ERASE_TIMEOUT],
             status_count[ST_WRITE_TIMEOUT], status_count[ST_VERIFY_MISMATCH], rejects,
             "commands dropped while busy");
    if (mismatches == 0) begin
      $display("tb_microwire_eeprom_controller: clean");
    end else begin
      $display("tb_microwire_eeprom_controller: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/mec_pkg.sv
src/mec_in_if.sv
src/mec_out_if.sv
src/mec_cfg_if.sv
src/microwire_eeprom_controller.sv
tb/tb_microwire_eeprom_controller.sv
